// File: src/matrix_chain_min_cost_unit_defines.svh
// ----------------------------------------------------------------------------
// matrix chain min cost unit: assertion macros
// shared concurrent assertion forms, clocked and gated by the active-low reset
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHAIN_MIN_COST_UNIT_DEFINES_SVH
`define MATRIX_CHAIN_MIN_COST_UNIT_DEFINES_SVH

// same-cycle implication
`define MCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcm assertion failed");

// next-cycle implication
`define MCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcm assertion failed");

`endif

// File: src/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// shared widths and the control flags that travel with each queued item
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

    localparam int DIM_W  = 10;
    localparam int COST_W = 40;
    localparam int PIJ_W  = 2 * DIM_W;
    localparam int PROD_W = 3 * DIM_W;

    typedef struct packed {
        logic store;
        logic last;
        logic err;
    } mcm_ctl_t;

endpackage

`default_nettype wire

// File: src/matrix_chain_min_cost_unit.sv
// an error or a single matrix gives done straight from the queue, with no fill; otherwise
//   done follows the cost table fill over all sub-chain lengths from 2 to N for N matrices,
//   run by the one-split-per-cycle cost table pipeline
// throughput: one item per cycle while the two-entry queue has room; busy rises once two
//   items wait behind a fill
// reset: asynchronous, clears the chain count, queue and fill control; stores are not cleared
// results are shown for one cycle with done and cannot be stalled
`default_nettype none

module matrix_chain_min_cost_unit #(
    parameter int MAX_MATRICES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [mcm_pkg::DIM_W-1:0]     dimension,
    input  wire logic                          last,
    output logic                               done,
    output logic [mcm_pkg::COST_W-1:0]         min_cost,
    output logic                               error
);

    localparam int SW    = $clog2(MAX_MATRICES + 1);
    localparam int CTL_W = $bits(mcm_pkg::mcm_ctl_t);
    localparam int QW    = mcm_pkg::DIM_W + SW + CTL_W;

    logic                        accept;
    logic                        push;
    logic [mcm_pkg::DIM_W-1:0]   f_dim;
    logic [SW-1:0]               f_slot;
    mcm_pkg::mcm_ctl_t           f_ctl;
    logic                        q_valid;
    logic                        q_full;
    logic                        q_pop;
    logic [QW-1:0]               q_rdata;
    logic [mcm_pkg::DIM_W-1:0]   b_dim;
    logic [SW-1:0]               b_slot;
    mcm_pkg::mcm_ctl_t           b_ctl;

    assign busy   = q_full;
    assign accept = start && !q_full;

    mcm_front #(
        .MAX_MATRICES (MAX_MATRICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .dimension (dimension),
        .last      (last),
        .push      (push),
        .q_dim     (f_dim),
        .q_slot    (f_slot),
        .q_ctl     (f_ctl)
    );

    mcm_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_dim, f_slot, f_ctl}),
        .pop   (q_pop),
        .valid (q_valid),
        .full  (q_full),
        .rdata (q_rdata)
    );

    assign b_dim  = q_rdata[QW-1 -: mcm_pkg::DIM_W];
    assign b_slot = q_rdata[CTL_W +: SW];
    assign b_ctl  = mcm_pkg::mcm_ctl_t'(q_rdata[CTL_W-1:0]);

    mcm_back #(
        .MAX_MATRICES (MAX_MATRICES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_dim    (b_dim),
        .q_slot   (b_slot),
        .q_ctl    (b_ctl),
        .q_pop    (q_pop),
        .done     (done),
        .min_cost (min_cost),
        .error    (error)
    );

endmodule

`default_nettype wire

// File: src/mcm_front.sv
// ----------------------------------------------------------------------------
// mcm_front
// counts the dimensions of the current chain and classifies each item
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_front #(
    parameter int MAX_MATRICES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [mcm_pkg::DIM_W-1:0]      dimension,
    input  wire logic                           last,
    output logic                                push,
    output logic [mcm_pkg::DIM_W-1:0]           q_dim,
    output logic [$clog2(MAX_MATRICES+1)-1:0]   q_slot,
    output mcm_pkg::mcm_ctl_t                   q_ctl
);

    localparam int SLOTS = MAX_MATRICES + 1;
    localparam int OVF   = MAX_MATRICES + 2;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(OVF + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] n_after;
    logic          store;

    assign store   = (count_reg < CW'(SLOTS));
    assign n_after = store ? (count_reg + CW'(1)) : CW'(OVF);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (last)
                count_next = '0;
            else
                count_next = n_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // overflowing items that are not last carry nothing downstream
    assign push        = accept && (store || last);
    assign q_dim       = dimension;
    assign q_slot      = SW'(count_reg);
    assign q_ctl.store = store;
    assign q_ctl.last  = last;
    assign q_ctl.err   = (n_after < CW'(2)) || (n_after > CW'(SLOTS));

endmodule

`default_nettype wire

// File: src/mcm_queue.sv
// ----------------------------------------------------------------------------
// mcm_queue
// two-entry item queue between the front and the fill engine
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    input  wire logic         pop,
    output logic              valid,
    output logic              full,
    output logic [W-1:0]      rdata
);

    logic [W-1:0] ent_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic         do_push;
    logic         do_pop;

    assign valid   = (cnt_reg != 2'd0);
    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// File: src/mcm_back.sv
// ----------------------------------------------------------------------------
// mcm_back
// stores dimensions and runs the cost table fill, one split per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_chain_min_cost_unit_defines.svh"

module mcm_back #(
    parameter int MAX_MATRICES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire logic [mcm_pkg::DIM_W-1:0]      q_dim,
    input  wire logic [$clog2(MAX_MATRICES+1)-1:0] q_slot,
    input  wire mcm_pkg::mcm_ctl_t              q_ctl,
    output logic                                q_pop,
    output logic                                done,
    output logic [mcm_pkg::COST_W-1:0]          min_cost,
    output logic                                error
);

    localparam int SLOTS  = MAX_MATRICES + 1;
    localparam int SW     = $clog2(SLOTS);
    localparam int MW     = $clog2(MAX_MATRICES + 1);
    localparam int TAB_D  = MAX_MATRICES * MAX_MATRICES;
    localparam int TAB_AW = (TAB_D > 1) ? $clog2(TAB_D) : 1;
    localparam int DIM_W  = mcm_pkg::DIM_W;
    localparam int COST_W = mcm_pkg::COST_W;
    localparam int PIJ_W  = mcm_pkg::PIJ_W;
    localparam int PROD_W = mcm_pkg::PROD_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PRE_I  = 7'b0000010,
        ST_PRE_J  = 7'b0000100,
        ST_PRE_M  = 7'b0001000,
        ST_SPLIT  = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_WRITE  = 7'b1000000
    } bk_state_t;

    function automatic logic [TAB_AW-1:0] tab_addr(input logic [MW-1:0] a,
                                                   input logic [MW-1:0] b);
        logic [31:0] t;
        t = (32'(a) - 32'd1) * 32'(MAX_MATRICES) + 32'(b) - 32'd1;
        return t[TAB_AW-1:0];
    endfunction

    bk_state_t          state_reg, state_next;
    logic [MW-1:0]      len_reg, len_next;
    logic [MW-1:0]      i_reg, i_next;
    logic [MW-1:0]      k_reg, k_next;
    logic [MW-1:0]      nm_reg, nm_next;
    logic               drain2_reg, drain2_next;
    logic               done_reg, done_next;
    logic               error_reg, error_next;
    logic [COST_W-1:0]  min_cost_reg, min_cost_next;
    logic               s1_v_reg, s2_v_reg;
    logic               have_reg;
    logic               za_reg, zb_reg;
    logic [DIM_W-1:0]   pi_reg;
    logic [PIJ_W-1:0]   pij_reg;
    logic [COST_W-1:0]  ab_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [COST_W-1:0]  best_reg;

    logic [DIM_W-1:0]   dim_mem [SLOTS];
    logic [DIM_W-1:0]   dim_q;
    logic [COST_W-1:0]  tab_mem [TAB_D];
    logic [COST_W-1:0]  ta_q, tb_q;

    logic [MW-1:0]      j_val;
    logic [MW-1:0]      k_inc;
    logic [SW-1:0]      dim_raddr;
    logic               tab_we;
    logic [COST_W-1:0]  a_val, b_val;
    logic [COST_W-1:0]  c_val;

    assign j_val = MW'({1'b0, i_reg} + {1'b0, len_reg} - {{MW{1'b0}}, 1'b1});
    assign k_inc = k_reg + MW'(1);
    assign q_pop = q_valid && (state_reg == ST_IDLE);
    assign tab_we = (state_reg == ST_WRITE);

    always_comb
    begin
        case (state_reg)
            ST_PRE_I: dim_raddr = SW'(i_reg - MW'(1));
            ST_PRE_J: dim_raddr = SW'(j_val);
            default:  dim_raddr = SW'(k_reg);
        endcase
    end

    // dimension store and cost table, registered reads
    always_ff @(posedge clk)
    begin
        if (q_pop && q_ctl.store)
            dim_mem[q_slot] <= q_dim;
        dim_q <= dim_mem[dim_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_addr(i_reg, j_val)] <= best_reg;
        ta_q <= tab_mem[tab_addr(i_reg, k_reg)];
        tb_q <= tab_mem[tab_addr(k_inc, j_val)];
    end

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        nm_next       = nm_reg;
        drain2_next   = 1'b0;
        done_next     = 1'b0;
        error_next    = error_reg;
        min_cost_next = min_cost_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_ctl.last)
                begin
                    if (q_ctl.err || (q_slot == SW'(1)))
                    begin
                        // error, or a single matrix that costs nothing
                        done_next     = 1'b1;
                        error_next    = q_ctl.err;
                        min_cost_next = '0;
                    end
                    else
                    begin
                        nm_next    = MW'(q_slot);
                        len_next   = MW'(2);
                        i_next     = MW'(1);
                        state_next = ST_PRE_I;
                    end
                end
            end
            ST_PRE_I:
                state_next = ST_PRE_J;
            ST_PRE_J:
                state_next = ST_PRE_M;
            ST_PRE_M:
            begin
                k_next     = i_reg;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                k_next = k_inc;
                if (k_inc == j_val)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                drain2_next = !drain2_reg;
                if (drain2_reg)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (len_reg == nm_reg)
                begin
                    done_next     = 1'b1;
                    error_next    = 1'b0;
                    min_cost_next = best_reg;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    if (j_val == nm_reg)
                    begin
                        len_next = len_reg + MW'(1);
                        i_next   = MW'(1);
                    end
                    else
                        i_next = i_reg + MW'(1);
                    state_next = ST_PRE_I;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            drain2_reg <= 1'b0;
            done_reg   <= 1'b0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            have_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            drain2_reg <= drain2_next;
            done_reg   <= done_next;
            s1_v_reg   <= (state_reg == ST_SPLIT);
            s2_v_reg   <= s1_v_reg;
            if (state_reg == ST_PRE_M)
                have_reg <= 1'b0;
            else if (s2_v_reg)
                have_reg <= 1'b1;
        end
    end

    // split pipeline: reads, then multiply and partial sum, then compare
    assign a_val = za_reg ? '0 : ta_q;
    assign b_val = zb_reg ? '0 : tb_q;
    assign c_val = ab_reg + {{(COST_W-PROD_W){1'b0}}, prod_reg};

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        nm_reg       <= nm_next;
        error_reg    <= error_next;
        min_cost_reg <= min_cost_next;
        za_reg       <= (k_reg == i_reg);
        zb_reg       <= (k_inc == j_val);
        ab_reg       <= a_val + b_val;
        prod_reg     <= {{DIM_W{1'b0}}, pij_reg} * {{PIJ_W{1'b0}}, dim_q};
        if (state_reg == ST_PRE_J)
            pi_reg <= dim_q;
        if (state_reg == ST_PRE_M)
            pij_reg <= {{DIM_W{1'b0}}, pi_reg} * {{DIM_W{1'b0}}, dim_q};
        if (s2_v_reg && (!have_reg || (c_val < best_reg)))
            best_reg <= c_val;
    end

    assign done     = done_reg;
    assign min_cost = min_cost_reg;
    assign error    = error_reg;

    `MCM_ASSERT_IMPL(a_split_k_below_j, clk, rst_n, state_reg == ST_SPLIT, k_reg < j_val)
    `MCM_ASSERT_IMPL(a_err_zero_cost, clk, rst_n, done_reg && error_reg, min_cost_reg == '0)
    `MCM_ASSERT_IMPL(a_write_drained, clk, rst_n, state_reg == ST_WRITE, !s1_v_reg && !s2_v_reg && have_reg)
    `MCM_ASSERT_NEXT(a_s2_follows_s1, clk, rst_n, s1_v_reg, s2_v_reg)

endmodule

`default_nettype wire

// File: tb/matrix_chain_min_cost_unit_test.sv
// ----------------------------------------------------------------------------
// matrix_chain_min_cost_unit_test
// Sends chains of matrix dimensions with start/busy, predicts the minimum
// multiplication count of each chain, and checks every done strobe against it.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_min_cost_unit_test;

    localparam int MAX_MATRICES = 16;
    localparam int DIM_SLOTS    = MAX_MATRICES + 1;
    localparam int DIM_W        = mcm_pkg::DIM_W;
    localparam int COST_W       = mcm_pkg::COST_W;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic [COST_W-1:0] min_cost;
        logic              error;
    } chain_result_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic [DIM_W-1:0] dimension = '0;
    logic             last      = 1'b0;
    logic             busy;
    logic             done;
    logic [COST_W-1:0] min_cost;
    logic             error;

    // predictor state: the dimensions of the chain being loaded
    logic [DIM_W-1:0] dim_store [DIM_SLOTS];
    int unsigned      dim_count = 0;

    chain_result_t pending_costs[$];

    int  failures        = 0;
    int  items_sent      = 0;
    int  chains_sent     = 0;
    int  error_chains    = 0;
    int  results_checked = 0;
    int  burst_left      = 0;
    bit  pacing_on       = 1'b0;

    matrix_chain_min_cost_unit #(
        .MAX_MATRICES(MAX_MATRICES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dimension(dimension),
        .last     (last),
        .done     (done),
        .min_cost (min_cost),
        .error    (error)
    );

    always #1 clk = ~clk;

    // bottom-up table over growing sub-chain lengths
    function automatic logic [COST_W-1:0] chain_cost(input int unsigned n);
        logic [63:0] m [1:MAX_MATRICES][1:MAX_MATRICES];
        logic [63:0] best;
        logic [63:0] c;
        logic [63:0] prod;
        int unsigned j;
        for (int unsigned i = 1; i < n; i++)
            m[i][i] = '0;
        best = '0;
        for (int unsigned len = 2; len < n; len++)
        begin
            for (int unsigned i = 1; i + len - 1 < n; i++)
            begin
                j = i + len - 1;
                for (int unsigned k = i; k < j; k++)
                begin
                    prod = 64'(dim_store[i-1]) * 64'(dim_store[k]) * 64'(dim_store[j]);
                    c = m[i][k] + m[k+1][j] + prod;
                    if (k == i || c < best)
                        best = c;
                end
                m[i][j] = best;
            end
        end
        return m[1][n-1][COST_W-1:0];
    endfunction

    task automatic predict_item(input logic [DIM_W-1:0] dim, input logic lst);
        chain_result_t r;
        int unsigned   n;
        if (dim_count < DIM_SLOTS)
        begin
            dim_store[dim_count] = dim;
            dim_count++;
        end
        else
        begin
            dim_count = DIM_SLOTS + 1;
        end
        if (lst)
        begin
            n = dim_count;
            dim_count = 0;
            if (n < 2 || n > DIM_SLOTS)
            begin
                r.min_cost = '0;
                r.error    = 1'b1;
                error_chains++;
            end
            else
            begin
                r.min_cost = chain_cost(n);
                r.error    = 1'b0;
            end
            pending_costs.push_back(r);
            chains_sent++;
        end
    endtask

    // sender works in bursts separated by random gaps
    task automatic pace_sender();
        if (pacing_on)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_dimension(input logic [DIM_W-1:0] dim, input logic lst);
        start     <= 1'b1;
        dimension <= dim;
        last      <= lst;
        do
            @(posedge clk);
        while (busy);
        predict_item(dim, lst);
        items_sent++;
        pace_sender();
    endtask

    function automatic logic [DIM_W-1:0] random_dimension();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        else if (r < 10)
            return '1;
        else if (r < 20)
            return DIM_W'($urandom_range(1, 4));
        else
            return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
    endfunction

    task automatic send_random_chain(input int len);
        for (int i = 0; i < len; i++)
            send_dimension(random_dimension(), i == len - 1);
    endtask

    task automatic send_constant_chain(input int len, input logic [DIM_W-1:0] dim);
        for (int i = 0; i < len; i++)
            send_dimension(dim, i == len - 1);
    endtask

    task automatic test_too_few_dimensions();
        send_dimension(DIM_W'(7), 1'b1);
        send_dimension('1, 1'b1);
    endtask

    task automatic test_single_matrix();
        send_dimension(DIM_W'(1), 1'b0);
        send_dimension('1, 1'b1);
        send_dimension('0, 1'b0);
        send_dimension(DIM_W'(512), 1'b1);
    endtask

    task automatic test_small_chains();
        send_dimension(DIM_W'(10), 1'b0);
        send_dimension(DIM_W'(30), 1'b0);
        send_dimension(DIM_W'(5), 1'b0);
        send_dimension(DIM_W'(60), 1'b1);
        // a zero dimension wipes out its products
        send_dimension('0, 1'b0);
        send_dimension(DIM_W'(5), 1'b0);
        send_dimension(DIM_W'(7), 1'b1);
        send_constant_chain(3, DIM_W'(1));
        send_constant_chain(4, '1);
        send_dimension(DIM_W'(341), 1'b0);
        send_dimension(DIM_W'(682), 1'b0);
        send_dimension(DIM_W'(1), 1'b1);
    endtask

    task automatic test_capacity_limits();
        pacing_on = 1'b1;
        send_constant_chain(DIM_SLOTS, '1);
        send_random_chain(DIM_SLOTS);
        // one past capacity, then well past it
        send_random_chain(DIM_SLOTS + 1);
        send_random_chain(DIM_SLOTS + 7);
        // count must start over after an overflowed chain
        send_random_chain(3);
        send_random_chain(DIM_SLOTS);
        send_dimension(random_dimension(), 1'b1);
        send_random_chain(2);
    endtask

    task automatic test_random_chains();
        int r;
        int len;
        while (items_sent < RANDOM_ITEMS)
        begin
            pacing_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 5)
                len = 1;
            else if (r < 11)
                len = $urandom_range(DIM_SLOTS + 1, DIM_SLOTS + 6);
            else if (r < 18)
                len = DIM_SLOTS;
            else if (r < 35)
                len = $urandom_range(9, DIM_SLOTS - 1);
            else
                len = $urandom_range(2, 8);
            send_random_chain(len);
        end
    endtask

    // results cannot be held off: check every strobe as it comes
    always @(posedge clk)
    begin
        chain_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_costs.size() == 0)
            begin
                $error("unexpected result: min_cost=%0d error=%0b", min_cost, error);
                failures++;
            end
            else
            begin
                want = pending_costs.pop_front();
                results_checked++;
                if (min_cost !== want.min_cost)
                begin
                    $error("min_cost: expected %0d, actual %0d", want.min_cost, min_cost);
                    failures++;
                end
                if (error !== want.error)
                begin
                    $error("error: expected %0b, actual %0b", want.error, error);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_too_few_dimensions();
        test_single_matrix();
        test_small_chains();
        test_capacity_limits();
        test_random_chains();

        start <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);

        $display("%0d chains in %0d dimension items, %0d results checked, %0d flagged as errors",
                 chains_sent, items_sent, results_checked, error_chains);
        if (failures == 0 && pending_costs.size() == 0)
            $display("matrix_chain_min_cost_unit test passed");
        else
            $display("matrix_chain_min_cost_unit test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("matrix_chain_min_cost_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
